// ===== rtl/core/tonp_pkg.sv =====
// ----------------------------------------------------------------------------
// tonp_pkg
// Shared constants and types for the telnet option negotiator: byte codes,
// option indexes, escape flags, reply beat phases and the burst descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

package tonp_pkg;

    // number of options with an on/off flag, and the bits to index them
    localparam int KNOWN_OPTIONS = 4;
    localparam int OPT_IDX_W     = (KNOWN_OPTIONS > 1) ? $clog2(KNOWN_OPTIONS) : 1;

    // telnet command bytes
    localparam logic [7:0] B_IAC  = 8'hFF;
    localparam logic [7:0] B_WILL = 8'hFB;
    localparam logic [7:0] B_WONT = 8'hFC;
    localparam logic [7:0] B_DO   = 8'hFD;
    localparam logic [7:0] B_DONT = 8'hFE;
    localparam logic [7:0] B_LF   = 8'h0A;

    // option indexes that have a reset value of on
    localparam logic [OPT_IDX_W-1:0] OPT_ECHO = OPT_IDX_W'(1);
    localparam logic [OPT_IDX_W-1:0] OPT_SGA  = OPT_IDX_W'(3);

    // option flags after reset: echo and suppress go-ahead on
    localparam logic [KNOWN_OPTIONS-1:0] OPT_RESET =
        KNOWN_OPTIONS'((1 << OPT_ECHO) | (1 << OPT_SGA));

    // escape state bits
    localparam logic [1:0] ESC_NONE = 2'b00;
    localparam logic [1:0] ESC_IAC  = 2'b01;
    localparam logic [1:0] ESC_VERB = 2'b10;

    // result kind
    localparam logic KIND_DISPLAY = 1'b0;
    localparam logic KIND_SEND    = 1'b1;

    // position inside a three-byte reply
    typedef enum logic [1:0] {
        PH_IAC  = 2'd0,
        PH_VERB = 2'd1,
        PH_OPT  = 2'd2
    } phase_t;

    // everything needed to play out the results of one input byte
    typedef struct packed {
        logic       is_reply;    // 1: one or two replies, 0: one display byte
        logic       two_replies; // second reply is always DONT
        logic [7:0] verb_a;      // verb of the first reply
        logic [7:0] data;        // display byte or option code
        logic       term;        // terminal mode after this byte
    } burst_t;

endpackage

`default_nettype wire

// ===== rtl/core/tonp_decode.sv =====
// ----------------------------------------------------------------------------
// tonp_decode
// Holds the escape state, pending verb, option flags and terminal mode, and
// works out in one pass what an input byte causes and how the state moves.
// ----------------------------------------------------------------------------
`default_nettype none

module tonp_decode
    import tonp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire logic [7:0] byte_in,
    input  wire logic       from_remote,
    output burst_t          burst,
    output logic            has_result
);

    logic [1:0]               esc_reg, esc_next;
    logic [7:0]               verb_reg, verb_next;
    logic [KNOWN_OPTIONS-1:0] opt_reg, opt_next;
    logic                     neg_reg, neg_next;

    logic                 is_verb;
    logic                 known;
    logic [OPT_IDX_W-1:0] opt_idx;
    logic                 cur_on;

    assign is_verb = byte_in inside {[B_WILL:B_DONT]};
    assign known   = byte_in < 8'(KNOWN_OPTIONS);
    assign opt_idx = byte_in[OPT_IDX_W-1:0];
    assign cur_on  = opt_reg[opt_idx];

    // next state and burst descriptor
    always_comb
    begin
        esc_next          = esc_reg;
        verb_next         = verb_reg;
        opt_next          = opt_reg;
        neg_next          = neg_reg;
        has_result        = 1'b0;
        burst.is_reply    = 1'b0;
        burst.two_replies = 1'b0;
        burst.verb_a      = B_DONT;
        burst.data        = byte_in;
        burst.term        = neg_reg;

        if (byte_in == B_IAC)
        begin
            esc_next = esc_reg | ESC_IAC;
        end
        else if (esc_reg[0] && is_verb)
        begin
            verb_next = byte_in;
            esc_next  = ESC_VERB;
        end
        else
        begin
            esc_next = ESC_NONE;
            if (!esc_reg[0] && esc_reg[1])
            begin
                // option code after a verb
                if (known)
                begin
                    neg_next   = 1'b1;
                    burst.term = 1'b1;
                    case (verb_reg)
                        B_WILL:
                        begin
                            if (cur_on)
                            begin
                                opt_next[opt_idx] = 1'b0;
                                has_result        = 1'b1;
                                burst.is_reply    = 1'b1;
                                burst.verb_a      = B_DO;
                            end
                        end
                        B_WONT:
                        begin
                            if (!cur_on)
                            begin
                                opt_next[opt_idx] = 1'b1;
                                has_result        = 1'b1;
                                burst.is_reply    = 1'b1;
                                burst.verb_a      = B_DONT;
                            end
                        end
                        B_DO:
                        begin
                            if (!cur_on)
                            begin
                                opt_next[opt_idx] = 1'b1;
                                has_result        = 1'b1;
                                burst.is_reply    = 1'b1;
                                burst.verb_a      = B_WILL;
                            end
                        end
                        B_DONT:
                        begin
                            if (cur_on)
                            begin
                                opt_next[opt_idx] = 1'b0;
                                has_result        = 1'b1;
                                burst.is_reply    = 1'b1;
                                burst.verb_a      = B_WONT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else
                begin
                    // fixed refusals for unknown options
                    case (verb_reg)
                        B_WILL:
                        begin
                            has_result     = 1'b1;
                            burst.is_reply = 1'b1;
                            burst.verb_a   = B_DONT;
                        end
                        B_DO:
                        begin
                            has_result        = 1'b1;
                            burst.is_reply    = 1'b1;
                            burst.two_replies = 1'b1;
                            burst.verb_a      = B_WONT;
                        end
                        B_DONT:
                        begin
                            has_result     = 1'b1;
                            burst.is_reply = 1'b1;
                            burst.verb_a   = B_WONT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            else if ((from_remote || opt_reg[OPT_ECHO]) && (neg_reg || byte_in != B_LF))
            begin
                // plain data byte to display
                has_result = 1'b1;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg  <= ESC_NONE;
            verb_reg <= 8'h00;
            opt_reg  <= OPT_RESET;
            neg_reg  <= 1'b0;
        end
        else if (take)
        begin
            esc_reg  <= esc_next;
            verb_reg <= verb_next;
            opt_reg  <= opt_next;
            neg_reg  <= neg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tonp_serial.sv =====
// ----------------------------------------------------------------------------
// tonp_serial
// Result register: holds one burst and plays it out one beat at a time,
// either a single display byte or one or two three-byte replies.
// ----------------------------------------------------------------------------
`default_nettype none

module tonp_serial
    import tonp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire burst_t     burst_in,
    output logic            can_load,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            kind,
    output logic [7:0]      byte_out,
    output logic            terminal_mode,
    output logic            last
);

    logic   valid_reg, valid_next;
    burst_t burst_reg, burst_next;
    phase_t phase_reg, phase_next;
    logic   second_reg, second_next;
    logic   beat_taken;

    assign out_valid     = valid_reg;
    assign kind          = burst_reg.is_reply ? KIND_SEND : KIND_DISPLAY;
    assign terminal_mode = burst_reg.term;
    assign last          = !burst_reg.is_reply ||
                           (phase_reg == PH_OPT && (!burst_reg.two_replies || second_reg));
    assign beat_taken    = valid_reg && out_ready;
    assign can_load      = !valid_reg || (out_ready && last);

    // beat byte select
    always_comb
    begin
        byte_out = burst_reg.data;
        if (burst_reg.is_reply)
        begin
            case (phase_reg)
                PH_IAC:  byte_out = B_IAC;
                PH_VERB: byte_out = second_reg ? B_DONT : burst_reg.verb_a;
                PH_OPT:  byte_out = burst_reg.data;
                default: byte_out = burst_reg.data;
            endcase
        end
    end

    // next burst position
    always_comb
    begin
        valid_next  = valid_reg;
        burst_next  = burst_reg;
        phase_next  = phase_reg;
        second_next = second_reg;
        if (can_load)
        begin
            valid_next  = load;
            burst_next  = burst_in;
            phase_next  = PH_IAC;
            second_next = 1'b0;
        end
        else if (beat_taken)
        begin
            case (phase_reg)
                PH_IAC:  phase_next = PH_VERB;
                PH_VERB: phase_next = PH_OPT;
                PH_OPT:
                begin
                    phase_next  = PH_IAC;
                    second_next = 1'b1;
                end
                default: phase_next = PH_IAC;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            phase_reg  <= PH_IAC;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            phase_reg  <= phase_next;
            second_reg <= second_next;
        end
    end

    // burst payload
    always_ff @(posedge clk)
    begin
        burst_reg <= burst_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/telnet_option_negotiator.sv =====
// ----------------------------------------------------------------------------
// telnet_option_negotiator
// Telnet IAC option negotiator with a serialized reply output.
// ----------------------------------------------------------------------------
// Takes one byte per beat and answers telnet WILL/WONT/DO/DONT negotiation
// with three-byte IAC replies (kind 1), or passes the byte on for display
// (kind 0) when it came from the host or echo is on. While out_ready stays
// high, bytes that cause zero or one result are taken at one per cycle. A
// negotiation that replies holds the output for 3 beats (6 for DO of an
// unknown option); the next input byte is taken in the cycle the final beat
// of that burst leaves, since a single result register carries the burst.
// in_ready follows out_ready in the same cycle: while any beat waits on
// out_ready, no input byte is taken, even one that causes no result.
// ----------------------------------------------------------------------------
`default_nettype none

module telnet_option_negotiator
    import tonp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] byte_in,
    input  wire logic       from_remote,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            kind,
    output logic [7:0]      byte_out,
    output logic            terminal_mode,
    output logic            last
);

    burst_t burst;
    logic   has_result;
    logic   take;

    assign take = in_valid && in_ready;

    // negotiation state and decode
    tonp_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .byte_in     (byte_in),
        .from_remote (from_remote),
        .burst       (burst),
        .has_result  (has_result)
    );

    // result register and beat serializer
    tonp_serial u_serial (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (take && has_result),
        .burst_in      (burst),
        .can_load      (in_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .byte_out      (byte_out),
        .terminal_mode (terminal_mode),
        .last          (last)
    );

endmodule

`default_nettype wire

// ===== rtl/core/tonp_checker.sv =====
// ----------------------------------------------------------------------------
// tonp_checker
// Port-level checks on the negotiator's beat sequencing, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module tonp_checker
    import tonp_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       kind,
    input wire logic [7:0] byte_out,
    input wire logic       last
);

    // a display beat is always a burst of one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_DISPLAY |-> last)
        else $error("display beat not marked last");

    // input is taken only once the pending burst is finished
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_valid |-> out_ready && last)
        else $error("input taken while burst still pending");

    // a reply header is followed at once by its verb
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && kind == KIND_SEND && byte_out == B_IAC && !last
        |=> out_valid && kind == KIND_SEND &&
            (byte_out == B_WILL || byte_out == B_WONT ||
             byte_out == B_DO || byte_out == B_DONT))
        else $error("reply header not followed by verb");

    // a stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(byte_out) && $stable(last))
        else $error("stalled output beat changed");

endmodule

bind telnet_option_negotiator tonp_checker u_tonp_checker (.*);

`default_nettype wire
